### hw/rtl/vor_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vor_pkg
// Shared types and constants of the voltage optimization regulator: field
// widths, register indexes, phase encoding and the divide-by-100 reciprocal.
// ----------------------------------------------------------------------------
package vor_pkg;

  // field widths
  localparam int unsigned VOLT_W = 16;
  localparam int unsigned CUR_W  = 16;
  localparam int unsigned SECS_W = 16;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned PCT_W  = 7;
  localparam int unsigned CODE_W = 3;

  // stream and config port widths
  localparam int unsigned IN_DATA_W  = 104;
  localparam int unsigned OUT_DATA_W = 40;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // averaging window default
  localparam int unsigned AVG_SAMPLES_DEF = 30;

  // v * pct product and exact reciprocal of 100 for products below 2^23
  localparam int unsigned PROD_W      = VOLT_W + PCT_W;
  localparam int unsigned RECIP_W     = 24;
  localparam int unsigned RECIP_SHIFT = 30;
  localparam logic [RECIP_W-1:0] RECIP_MUL = 24'd10737419;
  localparam int unsigned DEV_W       = PROD_W + RECIP_W - RECIP_SHIFT;

  // register reset values
  localparam logic [SECS_W-1:0] START_DELAY_RST = 16'd60;
  localparam logic [SECS_W-1:0] PAUSE_RST       = 16'd60;
  localparam logic [PCT_W-1:0]  SCALE_RST       = 7'd10;
  localparam logic [VOLT_W-1:0] STEP_RST        = 16'd10;
  localparam logic [VOLT_W-1:0] BASE_RST        = 16'd3800;
  localparam logic [CUR_W-1:0]  RATED_RST       = 16'd1000;

  // configuration register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_ENABLE      = 3'd0,
    REG_START_DELAY = 3'd1,
    REG_PAUSE       = 3'd2,
    REG_SCALE       = 3'd3,
    REG_STEP        = 3'd4,
    REG_BASE        = 3'd5,
    REG_RATED       = 3'd6
  } cfg_reg_e;

  // regulator phases, one-hot
  typedef enum logic [6:0] {
    PH_IDLE  = 7'b0000001,
    PH_WAIT  = 7'b0000010,
    PH_DOWN  = 7'b0000100,
    PH_CLEAR = 7'b0001000,
    PH_AVG   = 7'b0010000,
    PH_UP    = 7'b0100000,
    PH_PAUSE = 7'b1000000
  } phase_e;

  // reported state codes
  localparam logic [CODE_W-1:0] CODE_IDLE  = 3'd0;
  localparam logic [CODE_W-1:0] CODE_WAIT  = 3'd1;
  localparam logic [CODE_W-1:0] CODE_DOWN  = 3'd2;
  localparam logic [CODE_W-1:0] CODE_CLEAR = 3'd3;
  localparam logic [CODE_W-1:0] CODE_AVG   = 3'd4;
  localparam logic [CODE_W-1:0] CODE_UP    = 3'd5;
  localparam logic [CODE_W-1:0] CODE_PAUSE = 3'd6;

  // bounds of one captured point
  typedef struct packed {
    logic [VOLT_W-1:0] ceiling;
    logic [VOLT_W-1:0] floor;
  } bounds_t;

endpackage

### hw/rtl/vor_bounds.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vor_bounds
// Turns a registered v * scale_pct product into the deviation
// floor(v * pct / 100) and the ceiling and floor of the captured point.
// ----------------------------------------------------------------------------
module vor_bounds import vor_pkg::*; (
  input  logic [PROD_W-1:0] prod_i,
  input  logic [VOLT_W-1:0] volts_i,
  input  logic [VOLT_W-1:0] base_i,
  output bounds_t           bounds_o
);

  localparam int unsigned MUL_W = PROD_W + RECIP_W;

  logic [MUL_W-1:0]  recip_prod;
  logic [DEV_W-1:0]  dev;
  logic [DEV_W:0]    hi;

  // divide by 100 through the reciprocal
  assign recip_prod = MUL_W'(prod_i) * MUL_W'(RECIP_MUL);
  assign dev        = recip_prod[RECIP_SHIFT +: DEV_W];

  // ceiling capped at base voltage, floor clamped at zero
  assign hi = (DEV_W + 1)'(volts_i) + (DEV_W + 1)'(dev);

  always_comb begin
    if (hi > (DEV_W + 1)'(base_i)) begin
      bounds_o.ceiling = base_i;
    end else begin
      bounds_o.ceiling = hi[VOLT_W-1:0];
    end
    if (dev > DEV_W'(volts_i)) begin
      bounds_o.floor = '0;
    end else begin
      bounds_o.floor = volts_i - dev[VOLT_W-1:0];
    end
  end

endmodule

### hw/rtl/voltage_optimization_regulator_core.sv
`timescale 1ns / 1ps
// A tick request accepted on s_axis is loaded into the input register, passes the
//   regulator step and is loaded into the result register, from which it shows on m_axis.
// Throughput: one tick request per cycle while m_axis is not stalled, through an input
//   register and a result register with the regulator step between them.
// Reset: rst_ni clears the phase to idle, the point and bound state to zero
//   and the config registers to their defaults; no stream request is pending.
// ----------------------------------------------------------------------------
// voltage_optimization_regulator_core
// Per-tick V/f point optimizer: steps both points around the present frequency down while
// the averaged current neither rises nor exceeds the rated current, else back up.
// ----------------------------------------------------------------------------
module voltage_optimization_regulator_core import vor_pkg::*; #(
  parameter int unsigned AVG_SAMPLES = AVG_SAMPLES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // config write channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // tick requests
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // motor_stopping, motor_running, secs_since_start, freq_at_target,
  // point_found, upper_point_volts, lower_point_volts, avg_current, now_s
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // results
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // state_code, points_written, new_upper_volts, new_lower_volts
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  localparam int unsigned CNT_W = $clog2(AVG_SAMPLES + 1);
  localparam int unsigned SUM_W = CUR_W + CNT_W;
  localparam logic [SUM_W-1:0] AVG_K = SUM_W'(AVG_SAMPLES);
  localparam logic [CNT_W-1:0] AVG_N = CNT_W'(AVG_SAMPLES);

  // config registers
  logic              enable_q;
  logic [SECS_W-1:0] start_delay_q;
  logic [SECS_W-1:0] pause_period_q;
  logic [PCT_W-1:0]  scale_q;
  logic [VOLT_W-1:0] step_q;
  logic [VOLT_W-1:0] base_q;
  logic [CUR_W-1:0]  rated_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q       <= 1'b0;
      start_delay_q  <= START_DELAY_RST;
      pause_period_q <= PAUSE_RST;
      scale_q        <= SCALE_RST;
      step_q         <= STEP_RST;
      base_q         <= BASE_RST;
      rated_q        <= RATED_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        REG_ENABLE:      enable_q       <= cfg_data_i[0];
        REG_START_DELAY: start_delay_q  <= cfg_data_i;
        REG_PAUSE:       pause_period_q <= cfg_data_i;
        REG_SCALE:       scale_q        <= cfg_data_i[PCT_W-1:0];
        REG_STEP:        step_q         <= cfg_data_i;
        REG_BASE:        base_q         <= cfg_data_i;
        REG_RATED:       rated_q        <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // handshake of the two register stages
  logic in_valid_q, out_valid_q;
  logic advance, s_fire, tick;

  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign tick          = in_valid_q && advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= s_fire || (in_valid_q && !advance);
      out_valid_q <= tick || (out_valid_q && !m_axis_tready);
    end
  end

  // input register, with the bound products formed on the way in
  logic              stopping_q, running_q, at_target_q, found_q;
  logic [SECS_W-1:0] secs_q;
  logic [VOLT_W-1:0] up_in_q, lo_in_q;
  logic [CUR_W-1:0]  cur_q;
  logic [TIME_W-1:0] now_q;
  logic [PROD_W-1:0] up_prod_q, lo_prod_q;

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      stopping_q  <= s_axis_tdata[0];
      running_q   <= s_axis_tdata[1];
      secs_q      <= s_axis_tdata[17:2];
      at_target_q <= s_axis_tdata[18];
      found_q     <= s_axis_tdata[19];
      up_in_q     <= s_axis_tdata[35:20];
      lo_in_q     <= s_axis_tdata[51:36];
      cur_q       <= s_axis_tdata[67:52];
      now_q       <= s_axis_tdata[99:68];
      up_prod_q   <= PROD_W'(s_axis_tdata[35:20]) * PROD_W'(scale_q);
      lo_prod_q   <= PROD_W'(s_axis_tdata[51:36]) * PROD_W'(scale_q);
    end
  end

  // bounds of the captured points
  bounds_t up_bnd, lo_bnd;

  vor_bounds u_up_bounds (
    .prod_i   (up_prod_q),
    .volts_i  (up_in_q),
    .base_i   (base_q),
    .bounds_o (up_bnd)
  );

  vor_bounds u_lo_bounds (
    .prod_i   (lo_prod_q),
    .volts_i  (lo_in_q),
    .base_i   (base_q),
    .bounds_o (lo_bnd)
  );

  // step helpers
  function automatic logic [VOLT_W-1:0] step_down(
    input logic [VOLT_W-1:0] v,
    input logic [VOLT_W-1:0] stp,
    input logic [VOLT_W-1:0] fl
  );
    logic [VOLT_W-1:0] r;
    r = v - stp;
    if (stp > v || r < fl) begin
      return fl;
    end
    return r;
  endfunction

  function automatic logic [VOLT_W-1:0] step_up(
    input logic [VOLT_W-1:0] v,
    input logic [VOLT_W-1:0] stp,
    input logic [VOLT_W-1:0] cl
  );
    logic [VOLT_W:0] r;
    r = (VOLT_W + 1)'(v) + (VOLT_W + 1)'(stp);
    if (r > (VOLT_W + 1)'(cl)) begin
      return cl;
    end
    return r[VOLT_W-1:0];
  endfunction

  function automatic logic [CODE_W-1:0] phase_code(input phase_e ph);
    logic [CODE_W-1:0] c;
    unique case (ph)
      PH_IDLE:  c = CODE_IDLE;
      PH_WAIT:  c = CODE_WAIT;
      PH_DOWN:  c = CODE_DOWN;
      PH_CLEAR: c = CODE_CLEAR;
      PH_AVG:   c = CODE_AVG;
      PH_UP:    c = CODE_UP;
      PH_PAUSE: c = CODE_PAUSE;
      default:  c = CODE_IDLE;
    endcase
    return c;
  endfunction

  // regulator state
  phase_e            phase_q, phase_d;
  logic [VOLT_W-1:0] upper_q, upper_d, lower_q, lower_d;
  logic [VOLT_W-1:0] up_ceil_q, up_ceil_d, up_floor_q, up_floor_d;
  logic [VOLT_W-1:0] lo_ceil_q, lo_ceil_d, lo_floor_q, lo_floor_d;
  logic [CUR_W-1:0]  ref_cur_q, ref_cur_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [TIME_W-1:0] pause_start_q, pause_start_d;
  logic              written;
  phase_e            ph_entry;
  logic [SUM_W-1:0]  lim_ref, lim_rated;
  logic [TIME_W-1:0] elapsed;

  assign lim_ref   = AVG_K * SUM_W'(ref_cur_q);
  assign lim_rated = AVG_K * SUM_W'(rated_q);
  assign elapsed   = now_q - pause_start_q;

  // one regulator tick
  always_comb begin
    phase_d       = phase_q;
    upper_d       = upper_q;
    lower_d       = lower_q;
    up_ceil_d     = up_ceil_q;
    up_floor_d    = up_floor_q;
    lo_ceil_d     = lo_ceil_q;
    lo_floor_d    = lo_floor_q;
    ref_cur_d     = ref_cur_q;
    sum_d         = sum_q;
    cnt_d         = cnt_q;
    pause_start_d = pause_start_q;
    written       = 1'b0;

    // disabled or stopping motor forces idle
    ph_entry = (!enable_q || stopping_q) ? PH_IDLE : phase_q;

    unique case (ph_entry)
      PH_IDLE: begin
        phase_d = running_q ? PH_WAIT : PH_IDLE;
      end
      PH_WAIT: begin
        phase_d = PH_WAIT;
        if (secs_q > start_delay_q && at_target_q && found_q) begin
          upper_d    = up_in_q;
          lower_d    = lo_in_q;
          up_ceil_d  = up_bnd.ceiling;
          up_floor_d = up_bnd.floor;
          lo_ceil_d  = lo_bnd.ceiling;
          lo_floor_d = lo_bnd.floor;
          phase_d    = PH_DOWN;
        end
      end
      PH_DOWN: begin
        if (upper_q <= up_floor_q && lower_q <= lo_floor_q) begin
          phase_d       = PH_PAUSE;
          pause_start_d = now_q;
        end else begin
          ref_cur_d = cur_q;
          upper_d   = step_down(upper_q, step_q, up_floor_q);
          lower_d   = step_down(lower_q, step_q, lo_floor_q);
          written   = 1'b1;
          phase_d   = PH_CLEAR;
        end
      end
      PH_CLEAR: begin
        cnt_d   = '0;
        sum_d   = '0;
        phase_d = PH_AVG;
      end
      PH_AVG: begin
        phase_d = PH_AVG;
        if (cnt_q < AVG_N) begin
          sum_d = sum_q + SUM_W'(cur_q);
          cnt_d = cnt_q + CNT_W'(1);
        end else if (sum_q > lim_ref || sum_q > lim_rated) begin
          phase_d = PH_UP;
        end else begin
          phase_d = PH_DOWN;
        end
      end
      PH_UP: begin
        upper_d       = step_up(upper_q, step_q, up_ceil_q);
        lower_d       = step_up(lower_q, step_q, lo_ceil_q);
        written       = 1'b1;
        phase_d       = PH_PAUSE;
        pause_start_d = now_q;
      end
      PH_PAUSE: begin
        phase_d = (elapsed > TIME_W'(pause_period_q)) ? PH_DOWN : PH_PAUSE;
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_IDLE;
      upper_q       <= '0;
      lower_q       <= '0;
      up_ceil_q     <= '0;
      up_floor_q    <= '0;
      lo_ceil_q     <= '0;
      lo_floor_q    <= '0;
      ref_cur_q     <= '0;
      sum_q         <= '0;
      cnt_q         <= '0;
      pause_start_q <= '0;
    end else if (tick) begin
      phase_q       <= phase_d;
      upper_q       <= upper_d;
      lower_q       <= lower_d;
      up_ceil_q     <= up_ceil_d;
      up_floor_q    <= up_floor_d;
      lo_ceil_q     <= lo_ceil_d;
      lo_floor_q    <= lo_floor_d;
      ref_cur_q     <= ref_cur_d;
      sum_q         <= sum_d;
      cnt_q         <= cnt_d;
      pause_start_q <= pause_start_d;
    end
  end

  // result register
  logic [CODE_W-1:0] out_code_q;
  logic              out_written_q;
  logic [VOLT_W-1:0] out_upper_q, out_lower_q;

  always_ff @(posedge clk_i) begin
    if (tick) begin
      out_code_q    <= phase_code(phase_d);
      out_written_q <= written;
      out_upper_q   <= upper_d;
      out_lower_q   <= lower_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_lower_q, out_upper_q, out_written_q, out_code_q};

  // a point write only comes out of a step down or a step up
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_written_q) |-> (out_code_q == CODE_CLEAR || out_code_q == CODE_PAUSE))
    else $error("point write reported outside a step");

  // a disabled regulator or a stopping motor never gets past waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tick && (!enable_q || stopping_q)) |=> (out_code_q == CODE_IDLE || out_code_q == CODE_WAIT))
    else $error("forced idle not honored");

  // sample counter stays inside the window
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= AVG_N)
    else $error("sample count beyond averaging window");

  // a held result is not overwritten by the next tick
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |-> !tick)
    else $error("tick advanced over a stalled result");

  // an actual step down leaves both points at or above their floors
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tick && phase_q == PH_DOWN && enable_q && !stopping_q
      && (upper_q > up_floor_q || lower_q > lo_floor_q))
      |=> (upper_q >= up_floor_q && lower_q >= lo_floor_q))
    else $error("step down went below a floor");

endmodule
